// File: hw/rtl/isf_pkg.sv
// ----------------------------------------------------------------------------
// isf_pkg
// Shared constants, codes and command/status types of the INI section and
// key value finder.
// ----------------------------------------------------------------------------
package isf_pkg;

   // Name and value storage sizes.
   localparam int NAME_CHARS    = 8;
   localparam int VALUE_CHARS   = 32;
   localparam int VALUE_ADDR_W  = (VALUE_CHARS > 1) ? $clog2(VALUE_CHARS) : 1;
   localparam int VALUE_COUNT_W = $clog2(VALUE_CHARS + 1);

   // Field widths fixed by the register map.
   localparam int CFG_DATA_W      = 64;
   localparam int NAME_LEN_W      = 4;
   localparam int NAME_POS_W      = 4;
   localparam int MAX_CHARS_W     = 6;
   localparam int MAX_CHARS_RESET = 31;
   localparam int CSR_INDEX_W     = 3;
   localparam int CMP_W           = VALUE_COUNT_W + MAX_CHARS_W;

   localparam logic [NAME_POS_W-1:0] NAME_POS_MAX = '1;

   // Characters with a meaning in the text.
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SECTION_NAME    = 3'd0,
      CSR_SECTION_LENGTH  = 3'd1,
      CSR_KEY_NAME        = 3'd2,
      CSR_KEY_LENGTH      = 3'd3,
      CSR_MAX_VALUE_CHARS = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_TRUNCATED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      NAME_NONE,
      NAME_CLEAR,
      NAME_FEED_SECTION,
      NAME_FEED_KEY
   } name_op_type;

   typedef enum logic [1:0] {
      VAL_NONE,
      VAL_CLEAR,
      VAL_WRITE,
      VAL_OVERFLOW
   } val_op_type;

   typedef enum logic [1:0] {
      PUSH_NONE,
      PUSH_NOT_FOUND,
      PUSH_EMPTY,
      PUSH_BYTE
   } push_op_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_FIRST,
      RD_NEXT
   } rd_op_type;

   // Controller to datapath.
   typedef struct packed {
      logic        accept;
      name_op_type name_op;
      val_op_type  val_op;
      push_op_type push_op;
      rd_op_type   rd_op;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic restart;
      logic eot;
      logic is_semicolon;
      logic is_space;
      logic is_lbracket;
      logic is_rbracket;
      logic is_equals;
      logic is_lf;
      logic is_cr;
      logic section_match;
      logic key_match;
      logic value_room;
      logic value_empty;
      logic emit_last;
      logic out_full;
   } sts_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       has_byte;
      logic       last;
      status_type status;
   } rsp_payload_type;

endpackage

// File: hw/rtl/isf_if.sv
// ----------------------------------------------------------------------------
// isf_if
// Valid/ready channels of the finder: text request and value response.
// ----------------------------------------------------------------------------
interface isf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;
   logic       restart;

   modport source (output valid, output text_byte, output end_of_text, output restart,
                   input ready);
   modport sink   (input valid, input text_byte, input end_of_text, input restart,
                   output ready);
endinterface

interface isf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] value_byte;
   logic       has_byte;
   logic       last;
   logic [1:0] status;

   modport source (output valid, output value_byte, output has_byte, output last,
                   output status, input ready);
   modport sink   (input valid, input value_byte, input has_byte, input last,
                   input status, output ready);
endinterface

// File: hw/rtl/isf_ram.sv
// ----------------------------------------------------------------------------
// isf_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module isf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/isf_datapath.sv
// ----------------------------------------------------------------------------
// isf_datapath
// Configuration registers, byte decode, on-the-fly name compare, value store
// and the two-entry result queue.
// ----------------------------------------------------------------------------
module isf_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [isf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [isf_pkg::CFG_DATA_W-1:0]    csr_wdata,
   input  logic [7:0]                        text_byte,
   input  logic                              end_of_text,
   input  logic                              restart,
   input  isf_pkg::cmd_type                  cmd,
   output isf_pkg::sts_type                  sts,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output isf_pkg::rsp_payload_type          rsp_payload
);
   import isf_pkg::*;

   logic [CFG_DATA_W-1:0]  section_name_ff;
   logic [NAME_LEN_W-1:0]  section_length_ff;
   logic [CFG_DATA_W-1:0]  key_name_ff;
   logic [NAME_LEN_W-1:0]  key_length_ff;
   logic [MAX_CHARS_W-1:0] max_value_chars_ff;

   logic [NAME_POS_W-1:0]    name_pos_ff, name_pos_in, name_pos_base;
   logic                     name_mismatch_ff, name_mismatch_in, name_mismatch_base;
   logic [VALUE_COUNT_W-1:0] value_count_ff, value_count_in, value_count_base;
   logic                     value_overflow_ff, value_overflow_in, value_overflow_base;
   logic [VALUE_ADDR_W-1:0]  rd_idx_ff, rd_idx_in;

   logic [CFG_DATA_W-1:0] feed_word;
   logic [7:0]            want_byte;
   logic                  char_agrees;

   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [VALUE_ADDR_W-1:0] ram_rd_addr;
   logic [7:0]            ram_rd_data;

   rsp_payload_type head_ff, head_in, tail_ff, tail_in, push_data;
   logic            head_valid_ff, head_valid_in, tail_valid_ff, tail_valid_in;
   logic            push, pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         section_name_ff    <= '0;
         section_length_ff  <= '0;
         key_name_ff        <= '0;
         key_length_ff      <= '0;
         max_value_chars_ff <= MAX_CHARS_W'(MAX_CHARS_RESET);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SECTION_NAME:    section_name_ff    <= csr_wdata;
            CSR_SECTION_LENGTH:  section_length_ff  <= csr_wdata[NAME_LEN_W-1:0];
            CSR_KEY_NAME:        key_name_ff        <= csr_wdata;
            CSR_KEY_LENGTH:      key_length_ff      <= csr_wdata[NAME_LEN_W-1:0];
            CSR_MAX_VALUE_CHARS: max_value_chars_ff <= csr_wdata[MAX_CHARS_W-1:0];
            default: ;
         endcase
      end
   end

   // A restart clears the search state before the byte itself is handled, so
   // every decision is taken on these cleared values.
   always_comb begin
      name_pos_base       = restart ? '0 : name_pos_ff;
      name_mismatch_base  = restart ? 1'b0 : name_mismatch_ff;
      value_count_base    = restart ? '0 : value_count_ff;
      value_overflow_base = restart ? 1'b0 : value_overflow_ff;

      feed_word   = (cmd.name_op == NAME_FEED_SECTION) ? section_name_ff : key_name_ff;
      want_byte   = 8'(feed_word >> {name_pos_base[2:0], 3'b000});
      char_agrees = (name_pos_base < NAME_POS_W'(NAME_CHARS)) && (want_byte == text_byte);

      sts.restart       = restart;
      sts.eot           = end_of_text;
      sts.is_semicolon  = text_byte == CHAR_SEMICOLON;
      sts.is_space      = text_byte == CHAR_SPACE;
      sts.is_lbracket   = text_byte == CHAR_LBRACKET;
      sts.is_rbracket   = text_byte == CHAR_RBRACKET;
      sts.is_equals     = text_byte == CHAR_EQUALS;
      sts.is_lf         = text_byte == CHAR_LF;
      sts.is_cr         = text_byte == CHAR_CR;
      sts.section_match = !name_mismatch_base && (name_pos_base == section_length_ff);
      sts.key_match     = !name_mismatch_base && (name_pos_base == key_length_ff);
      sts.value_room    = (CMP_W'(value_count_base) < CMP_W'(VALUE_CHARS))
                          && (CMP_W'(value_count_base) < CMP_W'(max_value_chars_ff));
      sts.value_empty   = value_count_base == '0;
      sts.emit_last     = (VALUE_COUNT_W'(rd_idx_ff) + VALUE_COUNT_W'(1)) == value_count_ff;
      sts.out_full      = tail_valid_ff;
   end

   // Search state updates.
   always_comb begin
      name_pos_in       = name_pos_ff;
      name_mismatch_in  = name_mismatch_ff;
      value_count_in    = value_count_ff;
      value_overflow_in = value_overflow_ff;
      if (cmd.accept) begin
         name_pos_in       = name_pos_base;
         name_mismatch_in  = name_mismatch_base;
         value_count_in    = value_count_base;
         value_overflow_in = value_overflow_base;
         unique case (cmd.name_op)
            NAME_CLEAR: begin
               name_pos_in      = '0;
               name_mismatch_in = 1'b0;
            end
            NAME_FEED_SECTION, NAME_FEED_KEY: begin
               name_mismatch_in = name_mismatch_base | !char_agrees;
               if (name_pos_base != NAME_POS_MAX) begin
                  name_pos_in = name_pos_base + NAME_POS_W'(1);
               end
            end
            default: ;
         endcase
         unique case (cmd.val_op)
            VAL_CLEAR: begin
               value_count_in    = '0;
               value_overflow_in = 1'b0;
            end
            VAL_WRITE:    value_count_in    = value_count_base + VALUE_COUNT_W'(1);
            VAL_OVERFLOW: value_overflow_in = 1'b1;
            default: ;
         endcase
      end
   end

   // Value store and its read pointer.
   always_comb begin
      ram_wr_en   = cmd.accept && (cmd.val_op == VAL_WRITE);
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff;
      rd_idx_in   = rd_idx_ff;
      unique case (cmd.rd_op)
         RD_FIRST: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            rd_idx_in   = '0;
         end
         RD_NEXT: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = rd_idx_ff + VALUE_ADDR_W'(1);
            rd_idx_in   = rd_idx_ff + VALUE_ADDR_W'(1);
         end
         default: ;
      endcase
   end

   isf_ram #(
      .WIDTH (8),
      .DEPTH (VALUE_CHARS)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (value_count_base[VALUE_ADDR_W-1:0]),
      .wr_data (text_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Result queue: the head is shown on the port, the tail takes a result
   // while the head is stalled.
   always_comb begin
      push = cmd.push_op != PUSH_NONE;
      pop  = head_valid_ff && rsp_ready;

      push_data.value_byte = 8'h00;
      push_data.has_byte   = 1'b0;
      push_data.last       = 1'b1;
      push_data.status     = value_overflow_base ? STATUS_TRUNCATED : STATUS_FOUND;
      unique case (cmd.push_op)
         PUSH_NOT_FOUND: push_data.status = STATUS_NOT_FOUND;
         PUSH_BYTE: begin
            push_data.value_byte = ram_rd_data;
            push_data.has_byte   = 1'b1;
            push_data.last       = sts.emit_last;
            push_data.status     = value_overflow_ff ? STATUS_TRUNCATED : STATUS_FOUND;
         end
         default: ;
      endcase

      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      if (!head_valid_ff || pop) begin
         if (tail_valid_ff) begin
            head_in       = tail_ff;
            head_valid_in = 1'b1;
            tail_in       = push_data;
            tail_valid_in = push;
         end else begin
            head_in       = push_data;
            head_valid_in = push;
            tail_valid_in = 1'b0;
         end
      end else if (push) begin
         tail_in       = push_data;
         tail_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_pos_ff       <= '0;
         name_mismatch_ff  <= 1'b0;
         value_count_ff    <= '0;
         value_overflow_ff <= 1'b0;
         head_valid_ff     <= 1'b0;
         tail_valid_ff     <= 1'b0;
      end else begin
         name_pos_ff       <= name_pos_in;
         name_mismatch_ff  <= name_mismatch_in;
         value_count_ff    <= value_count_in;
         value_overflow_ff <= value_overflow_in;
         head_valid_ff     <= head_valid_in;
         tail_valid_ff     <= tail_valid_in;
      end
      rd_idx_ff <= rd_idx_in;
      head_ff   <= head_in;
      tail_ff   <= tail_in;
   end

   assign rsp_valid   = head_valid_ff;
   assign rsp_payload = head_ff;
endmodule

// File: hw/rtl/isf_ctrl.sv
// ----------------------------------------------------------------------------
// isf_ctrl
// Parser state machine: tracks the parse mode and skipped lines, and runs the
// read-out of a buffered value.
// ----------------------------------------------------------------------------
module isf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  isf_pkg::sts_type  sts,
   output isf_pkg::cmd_type  cmd
);
   import isf_pkg::*;

   typedef enum logic {
      CT_RUN,
      CT_EMIT
   } ctl_state_type;

   typedef enum logic [2:0] {
      MODE_SEEK,
      MODE_SECNAME,
      MODE_KEY,
      MODE_VALUE,
      MODE_IDLE
   } mode_type;

   ctl_state_type state_ff, state_in;
   mode_type      mode_ff, mode_in, mode_eff;
   logic          skip_ff, skip_in, skip_eff;
   logic          accept;
   logic          emit_value;

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      skip_in     = skip_ff;
      emit_value  = 1'b0;
      req_ready   = (state_ff == CT_RUN) && !sts.out_full;
      accept      = req_valid && req_ready;
      cmd.accept  = accept;
      cmd.name_op = NAME_NONE;
      cmd.val_op  = VAL_NONE;
      cmd.push_op = PUSH_NONE;
      cmd.rd_op   = RD_NONE;
      mode_eff    = sts.restart ? MODE_SEEK : mode_ff;
      skip_eff    = skip_ff && !sts.restart;

      unique case (state_ff)
         CT_RUN: begin
            if (accept) begin
               mode_in = mode_eff;
               skip_in = skip_eff;
               if (mode_eff != MODE_IDLE) begin
                  priority if (sts.eot) begin
                     cmd.push_op = PUSH_NOT_FOUND;
                     mode_in     = MODE_IDLE;
                  end else if (skip_eff) begin
                     if (sts.is_lf) begin
                        skip_in = 1'b0;
                        if (mode_eff == MODE_KEY) begin
                           cmd.name_op = NAME_CLEAR;
                        end
                     end
                  end else if (sts.is_semicolon) begin
                     if (mode_eff == MODE_VALUE) begin
                        emit_value = 1'b1;
                     end else begin
                        skip_in = 1'b1;
                        if (mode_eff == MODE_KEY) begin
                           cmd.name_op = NAME_CLEAR;
                        end
                     end
                  end else if (!sts.is_space) begin
                     unique case (mode_eff)
                        MODE_SEEK: begin
                           if (sts.is_lbracket) begin
                              mode_in     = MODE_SECNAME;
                              cmd.name_op = NAME_CLEAR;
                           end
                        end
                        MODE_SECNAME: begin
                           if (sts.is_rbracket) begin
                              cmd.name_op = NAME_CLEAR;
                              if (sts.section_match) begin
                                 mode_in = MODE_KEY;
                                 skip_in = 1'b1;
                              end else begin
                                 mode_in = MODE_SEEK;
                              end
                           end else begin
                              cmd.name_op = NAME_FEED_SECTION;
                           end
                        end
                        MODE_KEY: begin
                           priority if (sts.is_lbracket || sts.is_rbracket) begin
                              cmd.push_op = PUSH_NOT_FOUND;
                              mode_in     = MODE_IDLE;
                           end else if (sts.is_equals) begin
                              cmd.name_op = NAME_CLEAR;
                              if (sts.key_match) begin
                                 mode_in    = MODE_VALUE;
                                 cmd.val_op = VAL_CLEAR;
                              end else begin
                                 skip_in = 1'b1;
                              end
                           end else if (sts.is_lf || sts.is_cr) begin
                              cmd.name_op = NAME_CLEAR;
                           end else begin
                              cmd.name_op = NAME_FEED_KEY;
                           end
                        end
                        MODE_VALUE: begin
                           priority if (sts.is_lf || sts.is_cr) begin
                              emit_value = 1'b1;
                           end else if (sts.value_room) begin
                              cmd.val_op = VAL_WRITE;
                           end else begin
                              cmd.val_op = VAL_OVERFLOW;
                           end
                        end
                        default: mode_in = MODE_IDLE;
                     endcase
                  end
               end
               // The value ends: an empty one is a single result, otherwise
               // the store is read out one character per transfer.
               if (emit_value) begin
                  mode_in = MODE_IDLE;
                  if (sts.value_empty) begin
                     cmd.push_op = PUSH_EMPTY;
                  end else begin
                     cmd.rd_op = RD_FIRST;
                     state_in  = CT_EMIT;
                  end
               end
            end
         end
         CT_EMIT: begin
            if (!sts.out_full) begin
               cmd.push_op = PUSH_BYTE;
               if (sts.emit_last) begin
                  state_in = CT_RUN;
               end else begin
                  cmd.rd_op = RD_NEXT;
               end
            end
         end
         default: state_in = CT_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CT_RUN;
         mode_ff  <= MODE_SEEK;
         skip_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         skip_ff  <= skip_in;
      end
   end
endmodule

// File: hw/rtl/ini_section_key_value_finder.sv
// ----------------------------------------------------------------------------
// ini_section_key_value_finder
// Scans INI text for a configured key within a configured section and
// returns its value one character per response transfer.
// ----------------------------------------------------------------------------
// Usage: text enters on req_if, one byte per transfer, with end_of_text to
// mark the end of the file and restart to begin a new search. Section name,
// key name, their lengths and the value limit are written on the csr_ port
// while the block is idle.
// Throughput: one text byte per cycle while the text is scanned and the
// response queue has room. When a value ends, input is held while its
// characters are read out; the read of the first character is issued
// with the byte that ends the value. A not-found or empty-value response
// is pushed into the queue with the byte that caused it; each value
// character passes the value store's read register and then the queue.
// Responses pass through a two-entry queue, so scanning continues while a
// response waits; a stalled receiver holds input only once both entries are
// taken. Every response of a search carries the same status, and the final
// one has last set. After it, input is dropped until a restart.
// Reset clears the search and sets the registers to their defaults; the
// value store needs no clearing pass.
// ----------------------------------------------------------------------------
module ini_section_key_value_finder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [isf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [isf_pkg::CFG_DATA_W-1:0]  csr_wdata,
   isf_req_if.sink                         req_if,
   isf_rsp_if.source                       rsp_if
);
   import isf_pkg::*;

   cmd_type         cmd;
   sts_type         sts;
   rsp_payload_type rsp_payload;

   isf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   isf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .text_byte   (req_if.text_byte),
      .end_of_text (req_if.end_of_text),
      .restart     (req_if.restart),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_payload (rsp_payload)
   );

   assign rsp_if.value_byte = rsp_payload.value_byte;
   assign rsp_if.has_byte   = rsp_payload.has_byte;
   assign rsp_if.last       = rsp_payload.last;
   assign rsp_if.status     = rsp_payload.status;
endmodule

// File: hw/rtl/isf_checker.sv
// ----------------------------------------------------------------------------
// isf_checker
// Port-level checks on the finder's response channel.
// ----------------------------------------------------------------------------
module isf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] value_byte,
   input logic       has_byte,
   input logic       last,
   input logic [1:0] status
);
   import isf_pkg::*;

   // A stalled response stays and keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({value_byte, has_byte, last, status}))
      else $error("response changed while stalled");

   // A response without a character always ends the search.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !has_byte |-> last && value_byte == 8'h00)
      else $error("characterless response is not final or carries data");

   // Not found never carries a character.
   a_not_found_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_NOT_FOUND |-> !has_byte)
      else $error("not-found response carries a character");

   // Responses of one search share a status.
   a_status_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last ##1 rsp_valid |-> status == $past(status))
      else $error("status changed within a value");
endmodule

bind ini_section_key_value_finder isf_checker u_isf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .value_byte (rsp_if.value_byte),
   .has_byte   (rsp_if.has_byte),
   .last       (rsp_if.last),
   .status     (rsp_if.status)
);
